### rtl/core/fpw_pkg.sv
package fpw_pkg;

	localparam int PHYS_W  = 52;
	localparam int VA_W    = 48;
	localparam int ENTRY_W = 64;
	localparam int IDX_W   = 9;

	localparam logic [1:0] PAGE_4K = 2'd0;
	localparam logic [1:0] PAGE_2M = 2'd1;
	localparam logic [1:0] PAGE_1G = 2'd2;

	localparam logic KIND_REQUEST  = 1'b0;
	localparam logic KIND_RESPONSE = 1'b1;

	localparam logic RES_READ   = 1'b0;
	localparam logic RES_FINISH = 1'b1;

	localparam logic [1:0] LVL_ROOT = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	localparam logic REG_ROOT_BASE = 1'b0;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE   = 7;

	typedef struct packed {
		logic              result_kind;
		logic [PHYS_W-1:0] phys_address;
		logic              fault;
		logic [1:0]        map_size;
	} result_t;

	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
			input logic [1:0] level);
		logic [IDX_W-1:0] idx;
		unique case (level)
			LVL_ROOT: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

### rtl/core/fpw_walk.sv
module fpw_walk import fpw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               kind,
	input  logic [VA_W-1:0]    virtual_address,
	input  logic [ENTRY_W-1:0] entry_data,
	input  logic [PHYS_W-1:0]  root_base,
	output logic               res_valid,
	output result_t            res
);

	logic              busy_q;
	logic [1:0]        level_q;
	logic [VA_W-1:0]   va_q;

	logic              busy_d;
	logic [1:0]        level_d;
	logic [1:0]        level_nx;
	logic [PHYS_W-1:0] root_addr;

	assign level_nx  = level_q + 2'd1;
	assign root_addr = {root_base[PHYS_W-1:4], 4'b0000}
		+ {{(PHYS_W-IDX_W-3){1'b0}}, level_index(virtual_address, LVL_ROOT), 3'b000};

	always_comb begin
		busy_d             = busy_q;
		level_d            = level_q;
		res_valid          = 1'b0;
		res.result_kind    = RES_READ;
		res.phys_address   = '0;
		res.fault          = 1'b0;
		res.map_size       = PAGE_4K;
		if (kind == KIND_REQUEST) begin
			if (!busy_q) begin
				res_valid        = 1'b1;
				busy_d           = 1'b1;
				level_d          = LVL_ROOT;
				res.phys_address = root_addr;
			end
		end else if (busy_q) begin
			res_valid = 1'b1;
			priority if (level_q != LVL_PT && !entry_data[BIT_PRESENT]) begin
				res.result_kind = RES_FINISH;
				res.fault       = 1'b1;
				busy_d          = 1'b0;
				level_d         = LVL_ROOT;
			end else if (level_q == LVL_PDPT && entry_data[BIT_LARGE]) begin
				res.result_kind  = RES_FINISH;
				res.phys_address = {entry_data[51:30], va_q[29:0]};
				res.map_size     = PAGE_1G;
				busy_d           = 1'b0;
				level_d          = LVL_ROOT;
			end else if (level_q == LVL_PD && entry_data[BIT_LARGE]) begin
				res.result_kind  = RES_FINISH;
				res.phys_address = {16'd0, entry_data[35:21], va_q[20:0]};
				res.map_size     = PAGE_2M;
				busy_d           = 1'b0;
				level_d          = LVL_ROOT;
			end else if (level_q != LVL_PT) begin
				res.phys_address = {16'd0, entry_data[35:12],
					level_index(va_q, level_nx), 3'b000};
				level_d          = level_nx;
			end else if (entry_data[35:12] == '0) begin
				res.result_kind = RES_FINISH;
				res.fault       = 1'b1;
				busy_d          = 1'b0;
				level_d         = LVL_ROOT;
			end else begin
				res.result_kind  = RES_FINISH;
				res.phys_address = {16'd0, entry_data[35:12], va_q[11:0]};
				busy_d           = 1'b0;
				level_d          = LVL_ROOT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			level_q <= LVL_ROOT;
			va_q    <= '0;
		end else if (accept) begin
			busy_q  <= busy_d;
			level_q <= level_d;
			if (kind == KIND_REQUEST && !busy_q) begin
				va_q <= virtual_address;
			end
		end
	end

endmodule

### rtl/core/fpw_outq.sv
module fpw_outq import fpw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_word,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_word
);

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = count_q == 2'd2;
	assign out_valid = count_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_word  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/four_level_page_walker.sv
// Each result word is registered in the output queue before it reaches the outputs.
// Throughput: one input word per cycle while in_stall is low; the walk state updates in the same cycle.
// A two-entry output queue keeps accepting while one result waits downstream;
// in_stall rises only when both entries are held.
// Reset (arst_n, asynchronous): walker idle at the root level, queue empty,
// root table base zero.
module four_level_page_walker import fpw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [VA_W-1:0]    virtual_address,
	input  logic [ENTRY_W-1:0] entry_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [PHYS_W-1:0]  phys_address,
	output logic               fault,
	output logic [1:0]         map_size
);

	logic [PHYS_W-1:0] root_base_q;
	logic              accept;
	logic              res_valid;
	result_t           res;
	result_t           out_word;
	logic              q_full;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_ROOT_BASE) ? {12'd0, root_base_q} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_base_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[3] == REG_ROOT_BASE) begin
			root_base_q <= pwdata[PHYS_W-1:0];
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	fpw_walk u_walk (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.kind            (kind),
		.virtual_address (virtual_address),
		.entry_data      (entry_data),
		.root_base       (root_base_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	fpw_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_word (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign result_kind  = out_word.result_kind;
	assign phys_address = out_word.phys_address;
	assign fault        = out_word.fault;
	assign map_size     = out_word.map_size;

endmodule

### rtl/core/fpw_checker.sv
module fpw_checker import fpw_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              result_kind,
	input logic [PHYS_W-1:0] phys_address,
	input logic              fault,
	input logic [1:0]        map_size
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phys_address) && $stable(result_kind))
		else $error("stalled result word changed");

	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> result_kind == RES_FINISH && phys_address == '0
			&& map_size == PAGE_4K)
		else $error("fault word carries address or size");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_READ |-> !fault && map_size == PAGE_4K
			&& phys_address[2:0] == 3'b000)
		else $error("read request word malformed");

	a_size_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && map_size == PAGE_2M |-> phys_address[51:36] == '0)
		else $error("2 MiB result exceeds frame range");

endmodule

bind four_level_page_walker fpw_checker u_fpw_checker (.*);
